[design/ale_pkg.sv]
// shared constants, codes and types of the array list engine
package ale_pkg;

  localparam int DEPTH  = 256;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 9;

  // two-level priority encoder geometry
  localparam int GRP    = 16;
  localparam int GRP_W  = 4;
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
  localparam int GI_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int ENC_W  = GI_W + GRP_W;
  localparam int PAD_W  = NGRP * GRP;

  // operation codes
  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_MODIFY = 2'd1;
  localparam logic [1:0] MODE_APPEND = 2'd2;
  localparam logic [1:0] MODE_DELETE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic             wr_mod;
    logic             wr_app;
    logic             shift;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] count;
    logic [31:0]      value;
  } cell_cmd_t;

endpackage

[design/ale_in_if.sv]
// request channel of the array list engine
interface ale_in_if import ale_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [7:0]         position;
  logic signed [31:0] data_value;

  modport source (output valid, mode, position, data_value, input ready);
  modport sink   (input valid, mode, position, data_value, output ready);
endinterface

[design/ale_out_if.sv]
// response channel of the array list engine
interface ale_out_if import ale_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic [7:0]         found_position;
  logic signed [31:0] old_value;
  logic [8:0]         entry_count;

  modport source (output valid, status, found, found_position, old_value, entry_count,
                  input ready);
  modport sink   (input valid, status, found, found_position, old_value, entry_count,
                  output ready);
endinterface

[design/ale_cell.sv]
// one list cell: holds an entry, writes, shifts from its right neighbour, compares
module ale_cell import ale_pkg::*; (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [CMP_W-1:0] index_i,
  input  logic [31:0]      next_i,
  output logic [31:0]      entry_o,
  output logic             match_o
);

  logic [31:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.wr_mod && (index_i == cmd_i.pos)) begin
      entry_d = cmd_i.value;
    end
    if (cmd_i.wr_app && (index_i == cmd_i.count)) begin
      entry_d = cmd_i.value;
    end
    if (cmd_i.shift && (index_i >= cmd_i.pos)) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // only entries in use take part in a search
  assign match_o = (entry_q == cmd_i.value) && (index_i < cmd_i.count);

endmodule

[design/ale_enc.sv]
// two-level priority encoder: per-group lowest hit registered, then group select
module ale_enc import ale_pkg::*; (
  input  logic             clk_i,
  input  logic [DEPTH-1:0] match_i,
  output logic             hit_o,
  output logic [ENC_W-1:0] index_o
);

  logic [PAD_W-1:0] pad;
  logic [NGRP-1:0]  ghit_d, ghit_q;
  logic [GRP_W-1:0] glow_d [NGRP];
  logic [GRP_W-1:0] glow_q [NGRP];
  logic [GI_W-1:0]  gsel;

  assign pad = PAD_W'(match_i);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      ghit_d[g] = |pad[g*GRP +: GRP];
      glow_d[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (pad[g*GRP + b]) begin
          glow_d[g] = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ghit_q <= ghit_d;
    glow_q <= glow_d;
  end

  always_comb begin
    gsel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (ghit_q[g]) begin
        gsel = GI_W'(g);
      end
    end
  end

  assign hit_o   = |ghit_q;
  assign index_o = {gsel, glow_q[gsel]};

endmodule

[design/array_list_engine_top.sv]
// top level of the array list engine: cell row, encoder, control and result registers
// A packed list of DEPTH signed 32-bit entries kept in a row of cells, one entry per
// cell, plus a count of entries in use. Each request item runs one operation and gives
// exactly one response item. Modify, append and delete pass an accept cycle and an
// execute cycle, in which one cell writes or every cell from the position up takes its
// right neighbour's entry in parallel. For search the cells compare in the execute
// cycle and a two-level priority encoder (groups of 16 registered, then the group
// select) picks the lowest hit in the next. A new item is accepted once the previous
// one has executed, even while its response still waits on the output; one further
// finished response can be parked in a holding register. Entries have no reset and
// need no clearing pass, since only entries below the count are ever read.
module array_list_engine_top import ale_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ale_in_if.sink   req_i,
  ale_out_if.source rsp_o
);

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [7:0]  fpos;
    logic [31:0] old;
    logic [8:0]  count;
  } res_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  position;
    logic [31:0] value;
  } req_t;

  logic [1:0]       state_q, state_d;
  req_t             cmd_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, pend_q;
  res_t             out_q, pend_res_q;
  res_t             res;
  logic             fin;
  logic             accept;
  logic             can_load;

  cell_cmd_t        cell_cmd;
  logic [31:0]      entry_w [DEPTH];
  logic [DEPTH-1:0] match_w;
  logic             enc_hit;
  logic [ENC_W-1:0] enc_idx;
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic             pos_ok, full;
  logic [IDX_W-1:0] pos_idx;
  logic             exec;

  // request side: one item in flight, and no parked response
  assign req_i.ready = (state_q == S_IDLE) && !pend_q;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= '{mode: req_i.mode, position: req_i.position, value: req_i.data_value};
    end
  end

  // operand checks against the count of entries in use
  assign pos_w   = CMP_W'(cmd_q.position);
  assign cnt_w   = CMP_W'(count_q);
  assign pos_ok  = pos_w < cnt_w;
  assign full    = count_q == CNT_W'(DEPTH);
  assign pos_idx = IDX_W'(cmd_q.position);
  assign exec    = state_q == S_EXEC;

  // broadcast command to the row of cells
  always_comb begin
    cell_cmd.wr_mod = exec && (cmd_q.mode == MODE_MODIFY) && pos_ok;
    cell_cmd.wr_app = exec && (cmd_q.mode == MODE_APPEND) && !full;
    cell_cmd.shift  = exec && (cmd_q.mode == MODE_DELETE) && pos_ok;
    cell_cmd.pos    = pos_w;
    cell_cmd.count  = cnt_w;
    cell_cmd.value  = cmd_q.value;
  end

  // the cell row; the last cell takes its own entry on a shift (beyond the count)
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ale_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .index_i (CMP_W'(i)),
      .next_i  ((i == DEPTH - 1) ? entry_w[i] : entry_w[(i + 1) % DEPTH]),
      .entry_o (entry_w[i]),
      .match_o (match_w[i])
    );
  end

  ale_enc u_enc (
    .clk_i   (clk_i),
    .match_i (match_w),
    .hit_o   (enc_hit),
    .index_o (enc_idx)
  );

  // next count and sequencing
  always_comb begin
    count_d = count_q;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q.mode == MODE_SEARCH) begin
          state_d = S_SRCH;
        end else begin
          state_d = S_IDLE;
        end
        if (cell_cmd.wr_app) begin
          count_d = count_q + 1'b1;
        end
        if (cell_cmd.shift) begin
          count_d = count_q - 1'b1;
        end
      end
      S_SRCH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // response contents: updates finish in the execute cycle, search in the cycle after
  always_comb begin
    res        = '0;
    res.count  = 9'(count_d);
    fin        = 1'b0;
    if (exec && (cmd_q.mode != MODE_SEARCH)) begin
      fin = 1'b1;
      case (cmd_q.mode)
        MODE_MODIFY: begin
          if (pos_ok) begin
            res.old = entry_w[pos_idx];
          end else begin
            res.status = ST_BAD_POS;
          end
        end
        MODE_APPEND: begin
          if (full) begin
            res.status = ST_FULL;
          end
        end
        default: begin
          if (!pos_ok) begin
            res.status = ST_BAD_POS;
          end
        end
      endcase
    end else if (state_q == S_SRCH) begin
      fin       = 1'b1;
      res.found = enc_hit;
      res.fpos  = enc_hit ? 8'(enc_idx) : 8'd0;
    end
  end

  assign can_load = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (pend_q && can_load) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (fin) begin
        if (can_load) begin
          out_valid_q <= 1'b1;
        end else begin
          pend_q <= 1'b1;
        end
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response payload and holding register
  always_ff @(posedge clk_i) begin
    if (pend_q && can_load) begin
      out_q <= pend_res_q;
    end else if (fin) begin
      if (can_load) begin
        out_q <= res;
      end else begin
        pend_res_q <= res;
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.found          = out_q.found;
  assign rsp_o.found_position = out_q.fpos;
  assign rsp_o.old_value      = out_q.old;
  assign rsp_o.entry_count    = out_q.count;

`ifndef ASSERT_OFF
  // the count never passes the list depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a parked response only exists behind a waiting one
  a_pend_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("parked response without output response");

  // no item finishes while another response is parked
  a_fin_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fin && pend_q))
    else $error("response finished with holding register full");

  // an accepted item executes in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

  // count changes only when executing (the code steps it by at most one)
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == S_EXEC))
    else $error("count changed outside execute");
`endif

endmodule
